// ===== sv/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants for the coefficient forward quantizer.
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int COEFF_W  = 16;
    localparam int SCALE_W  = 15;
    localparam int SHIFT_W  = 5;
    localparam int OFFSET_W = 15;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SCALE        = 2'd0;
    localparam t_cfg_idx CFG_SHIFT        = 2'd1;
    localparam t_cfg_idx CFG_ROUND_OFFSET = 2'd2;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd16;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd27;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd20;

    localparam logic signed [COEFF_W-1:0] LEVEL_MIN = 16'sh8000;
    localparam logic signed [COEFF_W-1:0] LEVEL_MAX = 16'sh7fff;

endpackage

// ===== sv/coefficient_forward_quantizer.sv =====
// ----------------------------------------------------------------------------
// coefficient_forward_quantizer
// Quantizes signed coefficients by scale, rounding offset and shift, and
// tracks the coded-block flag across each block.
// ----------------------------------------------------------------------------
// an accepted item is held in the input register, then in the result register
// throughput: one item per cycle unless i_stall holds the output; multiply,
//   offset add and shift sit between the input and result registers; the
//   input stalls only while both registers hold an item and i_stall is high
// reset (synchronous, active low): empties both registers, clears the
//   nonzero-seen flag, sets scale = 0, shift = 20, round_offset = 0
module coefficient_forward_quantizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_coeff,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [15:0]            o_level,
    output logic                          o_coded_flag,
    output logic                          o_last_out,
    input  logic                          i_cfg_we,
    input  cfq_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [cfq_pkg::CFG_W-1:0]     i_cfg_data
);
    import cfq_pkg::*;

    // configuration
    logic [SCALE_W-1:0]  r_scale;
    logic [SHIFT_W-1:0]  r_shift;
    logic [OFFSET_W-1:0] r_round_offset;

    // input stage
    logic                      r_in_vld;
    logic signed [COEFF_W-1:0] r_coeff;
    logic                      r_last;

    // result stage
    logic                      r_out_vld;
    logic signed [COEFF_W-1:0] r_level;
    logic                      r_coded;
    logic                      r_last_out;

    logic r_nonzero_seen;

    logic                      out_free;
    logic                      in_take;
    logic [SHIFT_W-1:0]        sh;
    logic [3:0]                off_sh;
    logic                      neg;
    logic [COEFF_W:0]          mag;
    logic [31:0]               prod;
    logic [25:0]               off;
    logic [31:0]               sum;
    logic [31:0]               q_full;
    logic [COEFF_W-1:0]        q;
    logic signed [COEFF_W-1:0] n_level;
    logic                      n_coded;

    assign out_free = !r_out_vld || !i_stall;
    assign o_stall  = r_in_vld && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_comb begin
        if (r_shift < SHIFT_MIN) begin
            sh = SHIFT_MIN;
        end else if (r_shift > SHIFT_MAX) begin
            sh = SHIFT_MAX;
        end else begin
            sh = r_shift;
        end
        off_sh = 4'(sh - SHIFT_MIN);
        neg    = r_coeff[COEFF_W-1];
        // most negative coefficient gives 32768, hence the extra bit
        mag    = neg ? 17'(17'h10000 - {1'b0, r_coeff}) : {1'b0, r_coeff};
        prod   = 32'(mag) * 32'(r_scale);
        off    = 26'(r_round_offset) << off_sh;
        sum    = prod + 32'(off);
        q_full = sum >> sh;
        q      = q_full[COEFF_W-1:0];
        if (neg) begin
            if (q_full > 32'd32768) begin
                n_level = LEVEL_MIN;
            end else begin
                n_level = 16'(-$signed({1'b0, q}));
            end
        end else begin
            if (q_full > 32'd32767) begin
                n_level = LEVEL_MAX;
            end else begin
                n_level = $signed(q);
            end
        end
        n_coded = r_nonzero_seen || (n_level != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale        <= '0;
            r_shift        <= SHIFT_RESET;
            r_round_offset <= '0;
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_nonzero_seen <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCALE:        r_scale        <= i_cfg_data[SCALE_W-1:0];
                    CFG_SHIFT:        r_shift        <= i_cfg_data[SHIFT_W-1:0];
                    CFG_ROUND_OFFSET: r_round_offset <= i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            // the input register fills even while a stalled result waits
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (out_free) begin
                r_in_vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    // flag clears once the last item of a block leaves
                    r_nonzero_seen <= r_last ? 1'b0 : n_coded;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_coeff <= i_coeff;
            r_last  <= i_last;
        end
        if (out_free && r_in_vld) begin
            r_level    <= n_level;
            r_coded    <= n_coded;
            r_last_out <= r_last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_level      = r_level;
    assign o_coded_flag = r_coded;
    assign o_last_out   = r_last_out;

endmodule

// ===== sv/cfq_checker.sv =====
// ----------------------------------------------------------------------------
// cfq_checker
// Port-level checks on the coefficient forward quantizer.
// ----------------------------------------------------------------------------
module cfq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_level,
    input logic        o_coded_flag,
    input logic        o_last_out
);

    // the output comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_level)
            && $stable(o_coded_flag) && $stable(o_last_out))
        else $error("stalled result changed");

    // a nonzero level always marks the block as coded
    a_nonzero_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_level != 16'd0) |-> o_coded_flag)
        else $error("nonzero level without coded flag");

    // input is held off only when a result is waiting downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with output free");

endmodule

bind coefficient_forward_quantizer cfq_checker u_cfq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_level      (o_level),
    .o_coded_flag (o_coded_flag),
    .o_last_out   (o_last_out)
);
